[hdl/bdo_pkg.sv]
// Shared types and constants for the blinking disc overlay.
package bdo_pkg;

    // Width that holds any frame dimension up to 8192 plus one.
    localparam int DIM_W      = 14;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_FRAME_RATE   = 3'd2,
        REG_LUMA_COLOR   = 3'd3,
        REG_CB_COLOR     = 3'd4,
        REG_CR_COLOR     = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } plane_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [7:0]  frame_rate;
        logic [7:0]  luma_color;
        logic [7:0]  cb_color;
        logic [7:0]  cr_color;
    } cfg_t;

    typedef struct packed {
        plane_t plane;
        logic   show;
        logic   last;
    } item_ctl_t;

    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [7:0]  RST_FRAME_RATE   = 8'd30;
    localparam logic [7:0]  RST_LUMA_COLOR   = 8'd81;
    localparam logic [7:0]  RST_CB_COLOR     = 8'd90;
    localparam logic [7:0]  RST_CR_COLOR     = 8'd240;

endpackage

[hdl/bdo_regs.sv]
// Configuration register file written through the plain write port.
module bdo_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdo_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bdo_pkg::cfg_t                      cfg
);
    import bdo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                REG_FRAME_RATE:   cfg_next.frame_rate   = cfg_data[7:0];
                REG_LUMA_COLOR:   cfg_next.luma_color   = cfg_data[7:0];
                REG_CB_COLOR:     cfg_next.cb_color     = cfg_data[7:0];
                REG_CR_COLOR:     cfg_next.cr_color     = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.frame_rate   <= RST_FRAME_RATE;
            cfg_reg.luma_color   <= RST_LUMA_COLOR;
            cfg_reg.cb_color     <= RST_CB_COLOR;
            cfg_reg.cr_color     <= RST_CR_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/bdo_track.sv]
// Plane, row and column tracking plus the per-frame blink phase.
module bdo_track #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [7:0]                            frame_rate,
    input  logic [bdo_pkg::DIM_W-1:0]             luma_w,
    input  logic [bdo_pkg::DIM_W-1:0]             luma_h,
    output logic [$clog2(MAX_HEIGHT)-1:0]         row,
    output logic [$clog2(MAX_WIDTH)-1:0]          col,
    output bdo_pkg::item_ctl_t                    ctl
);
    import bdo_pkg::*;

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);

    plane_t           plane_reg, plane_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       phase_reg, phase_next;

    logic             frame_start;
    logic [8:0]       phase_inc;
    logic [7:0]       phase_upd;
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             col_wrap;
    logic             row_wrap;
    plane_t           plane_adv;

    always_comb
    begin
        frame_start = (plane_reg == PLANE_Y) && (row_reg == '0) && (col_reg == '0);
        phase_inc   = {1'b0, phase_reg} + 9'd1;
        phase_upd   = phase_reg;
        if (frame_start)
        begin
            if ((frame_rate == 8'd0) || (phase_inc >= {1'b0, frame_rate}))
                phase_upd = 8'd0;
            else
                phase_upd = phase_inc[7:0];
        end

        // Chroma planes are half size in both directions; a zero size counts as one.
        pw = (plane_reg == PLANE_Y) ? luma_w : (luma_w >> 1);
        ph = (plane_reg == PLANE_Y) ? luma_h : (luma_h >> 1);
        if (pw == '0)
            pw = DIM_W'(1);
        if (ph == '0)
            ph = DIM_W'(1);

        col_inc  = DIM_W'(col_reg) + DIM_W'(1);
        row_inc  = DIM_W'(row_reg) + DIM_W'(1);
        col_wrap = col_inc >= pw;
        row_wrap = row_inc >= ph;

        unique case (plane_reg)
            PLANE_Y:  plane_adv = PLANE_CB;
            PLANE_CB: plane_adv = PLANE_CR;
            PLANE_CR: plane_adv = PLANE_Y;
            default:  plane_adv = PLANE_Y;
        endcase

        plane_next = plane_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = phase_upd;
            if (col_wrap)
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    row_next   = '0;
                    plane_next = plane_adv;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        ctl.plane = plane_reg;
        ctl.show  = phase_upd < (frame_rate >> 1);
        ctl.last  = (plane_reg == PLANE_CR) && col_wrap && row_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PLANE_Y;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= 8'd0;
        end
        else
        begin
            plane_reg <= plane_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
        end
    end

    assign row = row_reg;
    assign col = col_reg;

endmodule

[hdl/bdo_disc.sv]
// Disc membership test for one luma sample or one chroma sample's four luma sites.
module bdo_disc #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic [bdo_pkg::DIM_W-1:0]         luma_w,
    input  bdo_pkg::plane_t                   plane,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     row,
    input  logic [$clog2(MAX_WIDTH)-1:0]      col,
    output logic                              in_disc
);
    import bdo_pkg::*;

    // The diameter never exceeds MAX_WIDTH / 32.
    localparam int D_W  = $clog2(MAX_WIDTH) - 4;
    localparam int SQ_W = 2 * (D_W + 1);

    logic [D_W-1:0]          diam;
    logic [D_W-1:0]          rad;
    logic [DIM_W-1:0]        d_lo;
    logic [DIM_W-1:0]        d_hi;
    logic [2*D_W-1:0]        rad_sq;
    logic [DIM_W-1:0]        coord [4];
    logic [DIM_W-1:0]        rel   [4];
    logic signed [D_W:0]     diff  [4];
    logic [SQ_W-1:0]         sq    [4];
    logic [3:0]              in_rng;
    logic [3:0]              hit;

    always_comb
    begin
        diam   = D_W'(luma_w >> 5);
        rad    = diam >> 1;
        d_lo   = DIM_W'(diam);
        d_hi   = d_lo << 1;
        rad_sq = (2*D_W)'(rad) * (2*D_W)'(rad);

        // Entries 0 and 1 are luma rows, 2 and 3 luma columns.
        if (plane == PLANE_Y)
        begin
            coord[0] = DIM_W'(row);
            coord[2] = DIM_W'(col);
        end
        else
        begin
            coord[0] = DIM_W'(row) << 1;
            coord[2] = DIM_W'(col) << 1;
        end
        coord[1] = coord[0] + DIM_W'(1);
        coord[3] = coord[2] + DIM_W'(1);

        for (int k = 0; k < 4; k++)
        begin
            in_rng[k] = (coord[k] >= d_lo) && (coord[k] < d_hi);
            rel[k]    = coord[k] - d_lo;
            diff[k]   = $signed({1'b0, rel[k][D_W-1:0]}) - $signed({1'b0, rad});
            sq[k]     = $unsigned(SQ_W'(diff[k]) * SQ_W'(diff[k]));
        end

        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                hit[2*i+j] = in_rng[i] && in_rng[2+j] &&
                             (((SQ_W+1)'(sq[i]) + (SQ_W+1)'(sq[2+j])) <
                              (SQ_W+1)'(rad_sq));
            end
        end

        in_disc = (plane == PLANE_Y) ? hit[0] : (|hit);
    end

endmodule

[hdl/blinking_disc_overlay_i420.sv]
// Top level of the blinking disc overlay for I420 sample streams.
//
//  Channel   Direction  Handshake          Payload
//  cfg       in         cfg_we             cfg_index, cfg_data
//  in        in         in_valid/in_stall  sample_in
//  out       out        out_valid/out_stall sample_out, frame_last
//
// One sample is taken every cycle while in_stall is low; each sample is
// held in the input register and its result then in the result register.
// Reset clears position, blink phase and the registers to their defaults.
// While the result register is stalled, one more sample is still taken into
// the input register; in_stall rises only when both registers are full.
module blinking_disc_overlay_i420 #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bdo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdo_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        sample_out,
    output logic                              frame_last
);
    import bdo_pkg::*;

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);

    cfg_t             cfg;
    logic [DIM_W-1:0] luma_w;
    logic [DIM_W-1:0] luma_h;
    logic             accept;
    logic             advance;

    logic [ROW_W-1:0] trk_row;
    logic [COL_W-1:0] trk_col;
    item_ctl_t        trk_ctl;
    logic [7:0]       color_sel;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_sample_reg;
    logic [7:0]       s1_color_reg;
    item_ctl_t        s1_ctl_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             disc_inside;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_sample_reg;
    logic             out_last_reg;

    bdo_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        luma_w = ({1'b0, cfg.frame_width} > DIM_W'(MAX_WIDTH)) ?
                 DIM_W'(MAX_WIDTH) : {1'b0, cfg.frame_width};
        luma_h = ({1'b0, cfg.frame_height} > DIM_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : {1'b0, cfg.frame_height};
    end

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    bdo_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_rate (cfg.frame_rate),
        .luma_w     (luma_w),
        .luma_h     (luma_h),
        .row        (trk_row),
        .col        (trk_col),
        .ctl        (trk_ctl)
    );

    always_comb
    begin
        unique case (trk_ctl.plane)
            PLANE_Y:  color_sel = cfg.luma_color;
            PLANE_CB: color_sel = cfg.cb_color;
            PLANE_CR: color_sel = cfg.cr_color;
            default:  color_sel = cfg.cr_color;
        endcase
    end

    bdo_disc #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_disc (
        .luma_w  (luma_w),
        .plane   (s1_ctl_reg.plane),
        .row     (s1_row_reg),
        .col     (s1_col_reg),
        .in_disc (disc_inside)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in;
            s1_color_reg  <= color_sel;
            s1_ctl_reg    <= trk_ctl;
            s1_row_reg    <= trk_row;
            s1_col_reg    <= trk_col;
        end
        if (advance && s1_valid_reg)
        begin
            out_sample_reg <= (s1_ctl_reg.show && disc_inside) ? s1_color_reg
                                                               : s1_sample_reg;
            out_last_reg   <= s1_ctl_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign frame_last = out_last_reg;

endmodule

[hdl/bdo_checker.sv]
// Port-level checker for the blinking disc overlay and its bind statement.
module bdo_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] sample_out,
    input logic       frame_last
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(frame_last))
        else $error("result changed while stalled");

    // The input side only backs up when the result side is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output could drain");

    // A result that appears on an empty output comes from an earlier input transaction.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input transaction");

endmodule

bind blinking_disc_overlay_i420 bdo_checker u_bdo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .frame_last (frame_last)
);
